// File: hdl/segment_intersection_defines.svh
// ---------------------------------------------------------------------------
// segment intersection assertion macros
// shared property forms for the checks at the end of the top level
// ---------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_DEFINES_SVH
`define SEGMENT_INTERSECTION_DEFINES_SVH

// same-cycle implication
`define SI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/segint_pkg.sv
// ---------------------------------------------------------------------------
// segint_pkg
// widths and types for the 2d segment intersection pipeline
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package segint_pkg;

  localparam int CW    = 16;            // coordinate bits
  localparam int FB    = 8;             // fraction bits of the result
  localparam int OW    = 24;            // result coordinate bits
  localparam int DW    = CW + 1;        // coordinate difference
  localparam int PW    = 2 * DW;        // difference product
  localparam int SW    = PW + 1;        // cross product sum
  localparam int MW    = CW + SW - 1;   // magnitude times parameter
  localparam int NW    = MW + FB;       // dividend
  localparam int QB    = CW + FB + 1;   // quotient bits
  localparam int RW    = SW + 1;        // partial remainder
  localparam int SUMW  = QB + 3;        // final add before saturation
  localparam int IN_W  = 8 * CW;
  localparam int OUT_W = 4 * OW;

  typedef struct packed {
    logic                 miss;
    logic                 coll;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic                 sx;
    logic                 sy;
    logic        [CW-1:0] emx;
    logic        [CW-1:0] emy;
    logic signed [CW-1:0] lx;
    logic signed [CW-1:0] ly;
    logic signed [CW-1:0] rx;
    logic signed [CW-1:0] ry;
  } side_t;

endpackage

// File: hdl/segment_intersection.sv
// ---------------------------------------------------------------------------
// segment_intersection
// exact intersection of two 2d segments with a pipelined restoring divider
// ---------------------------------------------------------------------------
// throughput: one transaction per cycle while the output is taken, set by the one-bit-per-stage divider
// the whole pipeline advances together; it holds while the output is not taken
// reset: rst clears all valid bits, payload registers are not reset
`timescale 1ns / 1ps

module segment_intersection
  import segint_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // ax, ay, bx, by, cx, cy, dx, dy
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // left_x, left_y, right_x, right_y
  output logic [1:0]       m_axis_tuser    // hit, overlap
);

  `include "segment_intersection_defines.svh"

  function automatic logic lex_less(logic signed [CW-1:0] x1, logic signed [CW-1:0] y1,
                                    logic signed [CW-1:0] x2, logic signed [CW-1:0] y2);
    return (x1 < x2) || ((x1 == x2) && (y1 < y2));
  endfunction

  function automatic logic span_meet(logic signed [CW-1:0] p, logic signed [CW-1:0] q,
                                     logic signed [CW-1:0] r, logic signed [CW-1:0] s);
    logic signed [CW-1:0] lo1, hi1, lo2, hi2, lmax, hmin;
    lo1  = (p < q) ? p : q;
    hi1  = (p < q) ? q : p;
    lo2  = (r < s) ? r : s;
    hi2  = (r < s) ? s : r;
    lmax = (lo1 < lo2) ? lo2 : lo1;
    hmin = (hi1 < hi2) ? hi1 : hi2;
    return lmax <= hmin;
  endfunction

  function automatic logic [RW:0] div_step(logic [RW-1:0] r, logic nb, logic [SW-2:0] d);
    logic [RW-1:0] rt;
    logic          ge;
    rt = {r[RW-2:0], nb};
    ge = rt >= RW'(d);
    return {ge, ge ? (rt - RW'(d)) : rt};
  endfunction

  function automatic logic signed [OW-1:0] sat(logic signed [SUMW-1:0] v);
    logic signed [SUMW-1:0] mx, mn;
    mx = SUMW'({1'b0, {(OW-1){1'b1}}});
    mn = -mx - SUMW'(1);
    if (v > mx) return {1'b0, {(OW-1){1'b1}}};
    if (v < mn) return {1'b1, {(OW-1){1'b0}}};
    return v[OW-1:0];
  endfunction

  logic en;
  logic v1, v2, v3, v4, v5, v6, v7;

  // stage 1: differences, bounding test, collinear ends
  logic signed [CW-1:0] iax, iay, ibx, iby, icx, icy, idx, idy;
  logic signed [CW-1:0] sax, say, sbx, sby, scx, scy, sdx, sdy;
  logic                 swap_ab, swap_cd, pick_c, pick_d;
  side_t                side_in, side1, side2, side3, side4, side5, side6;
  logic signed [DW-1:0] ex1, ey1, fx1, fy1, gx1, gy1;

  assign iax = s_axis_tdata[0*CW +: CW];
  assign iay = s_axis_tdata[1*CW +: CW];
  assign ibx = s_axis_tdata[2*CW +: CW];
  assign iby = s_axis_tdata[3*CW +: CW];
  assign icx = s_axis_tdata[4*CW +: CW];
  assign icy = s_axis_tdata[5*CW +: CW];
  assign idx = s_axis_tdata[6*CW +: CW];
  assign idy = s_axis_tdata[7*CW +: CW];

  always_comb begin
    swap_ab = lex_less(ibx, iby, iax, iay);
    swap_cd = lex_less(idx, idy, icx, icy);
    sax = swap_ab ? ibx : iax;
    say = swap_ab ? iby : iay;
    sbx = swap_ab ? iax : ibx;
    sby = swap_ab ? iay : iby;
    scx = swap_cd ? idx : icx;
    scy = swap_cd ? idy : icy;
    sdx = swap_cd ? icx : idx;
    sdy = swap_cd ? icy : idy;
    pick_c = lex_less(sax, say, scx, scy);
    pick_d = lex_less(sdx, sdy, sbx, sby);
    side_in      = '0;
    side_in.miss = !(span_meet(iax, ibx, icx, idx) && span_meet(iay, iby, icy, idy));
    side_in.ax   = iax;
    side_in.ay   = iay;
    side_in.lx   = pick_c ? scx : sax;
    side_in.ly   = pick_c ? scy : say;
    side_in.rx   = pick_d ? sdx : sbx;
    side_in.ry   = pick_d ? sdy : sby;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1 <= side_in;
      ex1   <= DW'(ibx) - DW'(iax);
      ey1   <= DW'(iby) - DW'(iay);
      fx1   <= DW'(idx) - DW'(icx);
      fy1   <= DW'(idy) - DW'(icy);
      gx1   <= DW'(icx) - DW'(iax);
      gy1   <= DW'(icy) - DW'(iay);
    end
  end

  // stage 2: cross products
  logic signed [PW-1:0] p_exfy, p_eyfx, p_gxfy, p_gyfx, p_gxey, p_gyex;
  logic signed [DW-1:0] aex, aey;

  always_comb begin
    aex = ex1[DW-1] ? -ex1 : ex1;
    aey = ey1[DW-1] ? -ey1 : ey1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2     <= side1;
      side2.sx  <= ex1[DW-1];
      side2.sy  <= ey1[DW-1];
      side2.emx <= aex[CW-1:0];
      side2.emy <= aey[CW-1:0];
      p_exfy    <= PW'(ex1) * PW'(fy1);
      p_eyfx    <= PW'(ey1) * PW'(fx1);
      p_gxfy    <= PW'(gx1) * PW'(fy1);
      p_gyfx    <= PW'(gy1) * PW'(fx1);
      p_gxey    <= PW'(gx1) * PW'(ey1);
      p_gyex    <= PW'(gy1) * PW'(ex1);
    end
  end

  // stage 3: determinant and parameter numerators
  logic signed [SW-1:0] den3, tn3, un3;

  always_ff @(posedge clk) begin
    if (en) begin
      side3 <= side2;
      den3  <= SW'(p_exfy) - SW'(p_eyfx);
      tn3   <= SW'(p_gxfy) - SW'(p_gyfx);
      un3   <= SW'(p_gxey) - SW'(p_gyex);
    end
  end

  // stage 4: sign normalize and range tests
  logic signed [SW-1:0] dn, tn, un;
  logic                 zero3, miss4;
  logic        [SW-2:0] den4, tn4;

  always_comb begin
    dn    = den3[SW-1] ? -den3 : den3;
    tn    = den3[SW-1] ? -tn3 : tn3;
    un    = den3[SW-1] ? -un3 : un3;
    zero3 = den3 == '0;
    if (zero3) begin
      miss4 = side3.miss || (tn3 != '0) || (un3 != '0);
    end else begin
      miss4 = side3.miss || (tn < 0) || (tn > dn) || (un < 0) || (un > dn);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4      <= side3;
      side4.miss <= miss4;
      side4.coll <= zero3 && !miss4;
      den4       <= dn[SW-2:0];
      tn4        <= tn[SW-2:0];
    end
  end

  // stage 5: scale offsets
  logic [MW-1:0] mx5, my5;
  logic [SW-2:0] den5;

  always_ff @(posedge clk) begin
    if (en) begin
      side5 <= side4;
      den5  <= den4;
      mx5   <= MW'(side4.emx) * MW'(tn4);
      my5   <= MW'(side4.emy) * MW'(tn4);
    end
  end

  // divider, one quotient bit per stage
  logic          dv    [0:QB];
  side_t         dside [0:QB];
  logic [SW-2:0] dden  [0:QB];
  logic [NW-1:0] dnx   [0:QB];
  logic [NW-1:0] dny   [0:QB];
  logic [RW-1:0] drx   [0:QB];
  logic [RW-1:0] dry   [0:QB];
  logic [QB-1:0] dqx   [0:QB];
  logic [QB-1:0] dqy   [0:QB];

  always_ff @(posedge clk) begin
    if (en) begin
      dside[0] <= side5;
      dden[0]  <= den5;
      dnx[0]   <= {mx5, {FB{1'b0}}};
      dny[0]   <= {my5, {FB{1'b0}}};
      drx[0]   <= RW'({mx5, {FB{1'b0}}} >> QB);
      dry[0]   <= RW'({my5, {FB{1'b0}}} >> QB);
      dqx[0]   <= '0;
      dqy[0]   <= '0;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [RW:0] stx, sty;
    assign stx = div_step(drx[k], dnx[k][QB-1-k], dden[k]);
    assign sty = div_step(dry[k], dny[k][QB-1-k], dden[k]);

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (en) begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dside[k+1] <= dside[k];
        dden[k+1]  <= dden[k];
        dnx[k+1]   <= dnx[k];
        dny[k+1]   <= dny[k];
        drx[k+1]   <= stx[RW-1:0];
        dry[k+1]   <= sty[RW-1:0];
        dqx[k+1]   <= {dqx[k][QB-2:0], stx[RW]};
        dqy[k+1]   <= {dqy[k][QB-2:0], sty[RW]};
      end
    end
  end

  // stage 6: round to nearest
  logic [QB:0] qx6, qy6;

  always_ff @(posedge clk) begin
    if (en) begin
      side6 <= dside[QB];
      qx6   <= (QB+1)'(dqx[QB]) + (QB+1)'({drx[QB], 1'b0} >= (RW+1)'(dden[QB]));
      qy6   <= (QB+1)'(dqy[QB]) + (QB+1)'({dry[QB], 1'b0} >= (RW+1)'(dden[QB]));
    end
  end

  // stage 7: add start point, saturate, select, output register
  logic signed [SUMW-1:0] offx, offy, sumx, sumy;
  logic signed [OW-1:0]   px, py;
  logic signed [OW-1:0]   lx7, ly7, rx7, ry7;
  logic                   hit7, ovl7;

  always_comb begin
    offx = side6.sx ? -SUMW'(qx6) : SUMW'(qx6);
    offy = side6.sy ? -SUMW'(qy6) : SUMW'(qy6);
    sumx = (SUMW'(side6.ax) <<< FB) + offx;
    sumy = (SUMW'(side6.ay) <<< FB) + offy;
    px   = sat(sumx);
    py   = sat(sumy);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (side6.miss) begin
        hit7 <= 1'b0;
        ovl7 <= 1'b0;
        lx7  <= '0;
        ly7  <= '0;
        rx7  <= '0;
        ry7  <= '0;
      end else if (side6.coll) begin
        hit7 <= 1'b1;
        ovl7 <= 1'b1;
        lx7  <= OW'(side6.lx) <<< FB;
        ly7  <= OW'(side6.ly) <<< FB;
        rx7  <= OW'(side6.rx) <<< FB;
        ry7  <= OW'(side6.ry) <<< FB;
      end else begin
        hit7 <= 1'b1;
        ovl7 <= 1'b0;
        lx7  <= px;
        ly7  <= py;
        rx7  <= px;
        ry7  <= py;
      end
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      v4    <= 1'b0;
      v5    <= 1'b0;
      dv[0] <= 1'b0;
      v6    <= 1'b0;
      v7    <= 1'b0;
    end else if (en) begin
      v1    <= s_axis_tvalid;
      v2    <= v1;
      v3    <= v2;
      v4    <= v3;
      v5    <= v4;
      dv[0] <= v5;
      v6    <= dv[QB];
      v7    <= v6;
    end
  end

  assign en            = !v7 || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = v7;
  assign m_axis_tdata  = {ry7, rx7, ly7, lx7};
  assign m_axis_tuser  = {ovl7, hit7};

  `SI_ASSERT_NOW(a_miss_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0, "miss with nonzero coordinates")
  `SI_ASSERT_NOW(a_overlap_hit, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0], "overlap without hit")
  `SI_ASSERT_NOW(a_point_same, m_axis_tvalid && m_axis_tuser[0] && !m_axis_tuser[1], (lx7 == rx7) && (ly7 == ry7), "single point with differing ends")
  `SI_ASSERT_NEXT(a_stall_hold, !s_axis_tready, m_axis_tvalid, "stalled result dropped")

endmodule
